/* rtl/c6502_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_pkg
// Types and constants shared by the 6502 instruction executor.
// ----------------------------------------------------------------------------
package c6502_pkg;

   typedef enum logic [3:0] {
      M_IMPL, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY,
      M_INDX, M_INDY, M_REL, M_IND
   } mode_type;

   typedef enum logic [4:0] {
      K_NONE, K_ADC, K_AND, K_ASL, K_LSR, K_BIT, K_BR, K_BRK, K_CLC, K_CLD,
      K_CLI, K_CLV, K_CMP, K_CPX, K_CPY, K_DEC, K_INC, K_DEX, K_DEY, K_INX,
      K_INY, K_EOR, K_JMP, K_JSR, K_LDA, K_LDX, K_LDY, K_STX
   } kind_type;

   typedef struct packed {
      kind_type kind;
      mode_type mode;
   } decode_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PTR_LO, ST_PTR_HI, ST_DATA, ST_EXEC, ST_PUSH,
      ST_OUT
   } state_type;

   localparam logic [15:0] VEC_RESET = 16'h8000;
   localparam logic [7:0]  SP_RESET  = 8'hFD;
   localparam logic [15:0] WINDOW    = 16'h2000;
   localparam logic [0:0]  CSR_RESET_VECTOR = 1'b0;
   localparam logic [0:0]  CSR_BREAK_VECTOR = 1'b1;

   // Opcode decode: instruction kind and addressing mode.
   function automatic decode_type decode(input logic [7:0] opc);
      decode_type d;
      d.kind = K_NONE;
      d.mode = M_IMPL;
      case (opc)
         8'h69: d = '{K_ADC, M_IMM};  8'h65: d = '{K_ADC, M_ZP};
         8'h75: d = '{K_ADC, M_ZPX};  8'h6D: d = '{K_ADC, M_ABS};
         8'h7D: d = '{K_ADC, M_ABSX}; 8'h79: d = '{K_ADC, M_ABSY};
         8'h61: d = '{K_ADC, M_INDX}; 8'h71: d = '{K_ADC, M_INDY};
         8'h29: d = '{K_AND, M_IMM};  8'h25: d = '{K_AND, M_ZP};
         8'h35: d = '{K_AND, M_ZPX};  8'h2D: d = '{K_AND, M_ABS};
         8'h3D: d = '{K_AND, M_ABSX}; 8'h39: d = '{K_AND, M_ABSY};
         8'h21: d = '{K_AND, M_INDX}; 8'h31: d = '{K_AND, M_INDY};
         8'h0A: d = '{K_ASL, M_ACC};  8'h06: d = '{K_ASL, M_ZP};
         8'h16: d = '{K_ASL, M_ZPX};  8'h0E: d = '{K_ASL, M_ABS};
         8'h1E: d = '{K_ASL, M_ABSX};
         8'h90, 8'hB0, 8'hF0, 8'h30, 8'hD0, 8'h50, 8'h70: d = '{K_BR, M_REL};
         8'h24: d = '{K_BIT, M_ZP};   8'h2C: d = '{K_BIT, M_ABS};
         8'h00: d = '{K_BRK, M_IMPL};
         8'h18: d = '{K_CLC, M_IMPL}; 8'hD8: d = '{K_CLD, M_IMPL};
         8'h58: d = '{K_CLI, M_IMPL}; 8'hB8: d = '{K_CLV, M_IMPL};
         8'hC9: d = '{K_CMP, M_IMM};  8'hC5: d = '{K_CMP, M_ZP};
         8'hD5: d = '{K_CMP, M_ZPX};  8'hCD: d = '{K_CMP, M_ABS};
         8'hDD: d = '{K_CMP, M_ABSX}; 8'hD9: d = '{K_CMP, M_ABSY};
         8'hC1: d = '{K_CMP, M_INDX}; 8'hD1: d = '{K_CMP, M_INDY};
         8'hE0: d = '{K_CPX, M_IMM};  8'hE4: d = '{K_CPX, M_ZP};
         8'hEC: d = '{K_CPX, M_ABS};
         8'hC0: d = '{K_CPY, M_IMM};  8'hC4: d = '{K_CPY, M_ZP};
         8'hCC: d = '{K_CPY, M_ABS};
         8'hC6: d = '{K_DEC, M_ZP};   8'hD6: d = '{K_DEC, M_ZPX};
         8'hCE: d = '{K_DEC, M_ABS};  8'hDE: d = '{K_DEC, M_ABSX};
         8'hCA: d = '{K_DEX, M_IMPL}; 8'h88: d = '{K_DEY, M_IMPL};
         8'h49: d = '{K_EOR, M_IMM};  8'h45: d = '{K_EOR, M_ZP};
         8'h55: d = '{K_EOR, M_ZPX};  8'h4D: d = '{K_EOR, M_ABS};
         8'h5D: d = '{K_EOR, M_ABSX}; 8'h59: d = '{K_EOR, M_ABSY};
         8'h41: d = '{K_EOR, M_INDX}; 8'h51: d = '{K_EOR, M_INDY};
         8'hE6: d = '{K_INC, M_ZP};   8'hF6: d = '{K_INC, M_ZPX};
         8'hEE: d = '{K_INC, M_ABS};  8'hFE: d = '{K_INC, M_ABSX};
         8'hE8: d = '{K_INX, M_IMPL}; 8'hC8: d = '{K_INY, M_IMPL};
         8'h4C: d = '{K_JMP, M_ABS};  8'h6C: d = '{K_JMP, M_IND};
         8'h20: d = '{K_JSR, M_ABS};
         8'hA9: d = '{K_LDA, M_IMM};  8'hA5: d = '{K_LDA, M_ZP};
         8'hB5: d = '{K_LDA, M_ZPX};  8'hAD: d = '{K_LDA, M_ABS};
         8'hBD: d = '{K_LDA, M_ABSX}; 8'hB9: d = '{K_LDA, M_ABSY};
         8'hA1: d = '{K_LDA, M_INDX}; 8'hB1: d = '{K_LDA, M_INDY};
         8'hA2: d = '{K_LDX, M_IMM};  8'hA6: d = '{K_LDX, M_ZP};
         8'hB6: d = '{K_LDX, M_ZPY};  8'hAE: d = '{K_LDX, M_ABS};
         8'hBE: d = '{K_LDX, M_ABSY};
         8'hA0: d = '{K_LDY, M_IMM};  8'hA4: d = '{K_LDY, M_ZP};
         8'hB4: d = '{K_LDY, M_ZPX};  8'hAC: d = '{K_LDY, M_ABS};
         8'hBC: d = '{K_LDY, M_ABSX};
         8'h4A: d = '{K_LSR, M_ACC};  8'h46: d = '{K_LSR, M_ZP};
         8'h56: d = '{K_LSR, M_ZPX};  8'h4E: d = '{K_LSR, M_ABS};
         8'h5E: d = '{K_LSR, M_ABSX};
         8'h86: d = '{K_STX, M_ZP};   8'h96: d = '{K_STX, M_ZPY};
         8'h8E: d = '{K_STX, M_ABS};
         default: d = '{K_NONE, M_IMPL};
      endcase
      return d;
   endfunction

endpackage

/* rtl/c6502_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_ram
// Single-port data RAM with a registered read, holding zero page and stack.
// ----------------------------------------------------------------------------
module c6502_ram #(
   parameter int AW = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [2**AW];

   // Write when enabled; the read is registered and always taken, returning the old byte during a write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

/* rtl/cpu_6502_instruction_execute.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_instruction_execute
// Executes one 6502 instruction per input transfer against held registers
// and a data RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one instruction: tdata holds the opcode, the
//   low operand byte and the high operand byte. The rsp_ channel returns the
//   register file after the instruction and a report of its last RAM write.
//   The csr_ channel writes the reset vector (index 0) and break vector
//   (index 1); every reset returns the reset vector to 0x8000 before it is
//   loaded, so the program counter always starts there.
// Sequencing:
//   An instruction passes through PTR_LO, PTR_HI for a pointer fetch, DATA
//   for a data read, EXEC, PUSH for the stack pushes of JSR and BRK, and
//   OUT; the single RAM port serialises every read and write. One
//   instruction is in flight at a time.
// Reset:
//   After reset a clearing pass zeroes the RAM, one byte a cycle, through
//   all RAM_DEPTH addresses; no instruction is taken meanwhile.
// Stall:
//   A result is held in the output register until it is taken; the next
//   instruction is accepted only after that.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_execute
   import c6502_pkg::*;
#(
   parameter int RAM_DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[7:0], operand_low[15:8], operand_high[23:16]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc[15:0], acc_out[23:16], x_out[31:24], y_out[39:32],
   // sp_out[47:40], flags_out[55:48], wrote_memory[56],
   // last_write_address[72:57], last_write_data[80:73], unknown_opcode[81],
   // zero padding[87:82]
   output logic [87:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(RAM_DEPTH);

   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [15:0] bvec_ff;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  opc_ff, lo_ff, hi_ff;
   decode_type  dec_ff;
   logic [15:0] ea_ff, ea_in;
   logic [7:0]  m_ff, m_in;
   logic [1:0]  push_ff, push_in;
   logic        wr_ff, wr_in;
   logic [15:0] wa_ff, wa_in;
   logic [7:0]  wd_ff, wd_in;
   logic        rv_ff, rv_in;
   logic [87:0] out_ff, out_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wd, ram_rd;
   logic [15:0]   rd_addr;
   logic          rd_ok_ff, rd_ok_in;
   logic [7:0]    rd_val;

   c6502_ram #(.AW(AW)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   // Reads outside the window return zero.
   assign rd_val = rd_ok_ff ? ram_rd : 8'h00;

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = out_ff;

   // Configuration registers. The reset vector is back at its reset value
   // whenever it is loaded, so only the break vector needs storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         bvec_ff <= VEC_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_BREAK_VECTOR) bvec_ff <= csr_data;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(RAM_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid && req_tready) state_in = ST_PTR_LO;
         ST_PTR_LO: begin
            case (dec_ff.mode)
               M_INDX, M_INDY, M_IND: state_in = ST_PTR_HI;
               M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY:
                  state_in = (dec_ff.kind == K_STX || dec_ff.kind == K_JMP
                              || dec_ff.kind == K_JSR) ? ST_EXEC : ST_DATA;
               default: state_in = ST_EXEC;
            endcase
         end
         ST_PTR_HI: state_in = (dec_ff.mode == M_IND) ? ST_EXEC : ST_DATA;
         ST_DATA:   state_in = ST_EXEC;
         ST_EXEC:   state_in = (dec_ff.kind == K_BRK || dec_ff.kind == K_JSR) ?
                               ST_PUSH : ST_OUT;
         ST_PUSH:   if (push_ff == 2'd0) state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      logic [8:0]  sum;
      logic [7:0]  r, cmpr;
      logic [15:0] base, ret;
      logic        want, flag;
      clr_in = clr_ff;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; p_in = p_ff;
      pc_in = pc_ff; ea_in = ea_ff; m_in = m_ff; push_in = push_ff;
      wr_in = wr_ff; wa_in = wa_ff; wd_in = wd_ff;
      rv_in = rv_ff; out_in = out_ff;
      ram_we = 1'b0; ram_wd = 8'h00; rd_addr = 16'h0000; rd_ok_in = 1'b0;
      base = {hi_ff, lo_ff};
      ret = pc_ff + 16'd2;
      sum = 9'h000; r = 8'h00; cmpr = 8'h00; want = 1'b0; flag = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            rd_addr = {{(16 - AW){1'b0}}, clr_ff};
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            wr_in = 1'b0; wa_in = 16'h0000; wd_in = 8'h00;
         end
         ST_PTR_LO: begin
            m_in = lo_ff;
            if (dec_ff.mode == M_ACC) m_in = a_ff;
            case (dec_ff.mode)
               M_ZP:   ea_in = {8'h00, lo_ff};
               M_ZPX:  ea_in = {8'h00, lo_ff + x_ff};
               M_ZPY:  ea_in = {8'h00, lo_ff + y_ff};
               M_ABS:  ea_in = base;
               M_ABSX: ea_in = base + {8'h00, x_ff};
               M_ABSY: ea_in = base + {8'h00, y_ff};
               M_INDX: ea_in = {8'h00, lo_ff + x_ff};
               M_INDY: ea_in = {8'h00, lo_ff};
               M_IND:  ea_in = base;
               default: ea_in = 16'h0000;
            endcase
            rd_addr = ea_in;
            rd_ok_in = ea_in < WINDOW;
         end
         ST_PTR_HI: begin
            // Pointer low byte is back; fetch the high byte within its page.
            m_in = rd_val;
            rd_addr = {ea_ff[15:8], ea_ff[7:0] + 8'd1};
            rd_ok_in = rd_addr < WINDOW;
         end
         ST_DATA: begin
            if (dec_ff.mode == M_INDX || dec_ff.mode == M_INDY) begin
               ea_in = {rd_val, m_ff};
               if (dec_ff.mode == M_INDY) ea_in = {rd_val, m_ff} + {8'h00, y_ff};
            end
            rd_addr = ea_in;
            rd_ok_in = ea_in < WINDOW;
         end
         ST_EXEC: begin
            if (dec_ff.mode == M_IND) begin
               ea_in = {rd_val, m_ff};
            end else if (dec_ff.mode != M_IMM && dec_ff.mode != M_ACC &&
                         dec_ff.mode != M_IMPL && dec_ff.mode != M_REL &&
                         dec_ff.kind != K_STX && dec_ff.kind != K_JMP &&
                         dec_ff.kind != K_JSR) begin
               m_in = rd_val;
            end
            case (dec_ff.mode)
               M_IMPL, M_ACC: pc_in = pc_ff + 16'd1;
               M_ABS, M_ABSX, M_ABSY, M_IND: pc_in = pc_ff + 16'd3;
               default: pc_in = pc_ff + 16'd2;
            endcase
            r = 8'h00;
            case (dec_ff.kind)
               K_ADC: begin
                  sum = {1'b0, a_ff} + {1'b0, m_in} + {8'h00, p_ff[0]};
                  r = sum[7:0];
                  p_in[0] = sum[8];
                  p_in[6] = ~(a_ff[7] ^ m_in[7]) & (a_ff[7] ^ r[7]);
                  a_in = r; p_in[1] = (r == 8'h00); p_in[7] = r[7];
               end
               K_AND, K_EOR: begin
                  r = (dec_ff.kind == K_AND) ? (a_ff & m_in) : (a_ff ^ m_in);
                  a_in = r; p_in[1] = (r == 8'h00); p_in[7] = r[7];
               end
               K_ASL, K_LSR, K_INC, K_DEC: begin
                  case (dec_ff.kind)
                     K_ASL: begin r = {m_in[6:0], 1'b0}; p_in[0] = m_in[7]; end
                     K_LSR: begin r = {1'b0, m_in[7:1]}; p_in[0] = m_in[0]; end
                     K_INC: r = m_in + 8'd1;
                     default: r = m_in - 8'd1;
                  endcase
                  p_in[1] = (r == 8'h00); p_in[7] = r[7];
                  if (dec_ff.mode == M_ACC) begin
                     a_in = r;
                  end else if (ea_ff < WINDOW) begin
                     ram_we = 1'b1; ram_wd = r; rd_addr = ea_ff;
                     wr_in = 1'b1; wa_in = ea_ff; wd_in = r;
                  end
               end
               K_STX: begin
                  if (ea_ff < WINDOW) begin
                     ram_we = 1'b1; ram_wd = x_ff; rd_addr = ea_ff;
                     wr_in = 1'b1; wa_in = ea_ff; wd_in = x_ff;
                  end
               end
               K_BIT: begin
                  p_in[7] = m_in[7]; p_in[6] = m_in[6];
                  p_in[1] = ((m_in & a_ff) == 8'h00);
               end
               K_BR: begin
                  want = opc_ff[5];
                  case (opc_ff[7:6])
                     2'd0: flag = p_ff[7];
                     2'd1: flag = p_ff[6];
                     2'd2: flag = p_ff[0];
                     default: flag = p_ff[1];
                  endcase
                  if (flag == want) pc_in = pc_ff + 16'd2 + {{8{lo_ff[7]}}, lo_ff};
               end
               K_BRK: begin
                  // First push: return address high byte. The low byte is
                  // kept for the next push, since the program counter moves on.
                  ram_we = 1'b1; ram_wd = ret[15:8]; rd_addr = {8'h01, sp_ff};
                  wr_in = 1'b1; wa_in = rd_addr; wd_in = ram_wd;
                  sp_in = sp_ff - 8'd1; push_in = 2'd2;
                  m_in = ret[7:0];
                  pc_in = bvec_ff;
               end
               K_JSR: begin
                  ram_we = 1'b1; ram_wd = ret[15:8]; rd_addr = {8'h01, sp_ff};
                  wr_in = 1'b1; wa_in = rd_addr; wd_in = ram_wd;
                  sp_in = sp_ff - 8'd1; push_in = 2'd1;
                  m_in = ret[7:0];
                  pc_in = ea_ff;
               end
               K_CLC: p_in[0] = 1'b0;
               K_CLD: p_in[3] = 1'b0;
               K_CLI: p_in[2] = 1'b0;
               K_CLV: p_in[6] = 1'b0;
               K_CMP, K_CPX, K_CPY: begin
                  cmpr = (dec_ff.kind == K_CMP) ? a_ff :
                         (dec_ff.kind == K_CPX) ? x_ff : y_ff;
                  r = cmpr - m_in;
                  p_in[1] = (r == 8'h00); p_in[7] = r[7];
                  p_in[0] = (cmpr >= m_in);
               end
               K_DEX, K_INX: begin
                  r = (dec_ff.kind == K_INX) ? x_ff + 8'd1 : x_ff - 8'd1;
                  x_in = r; p_in[1] = (r == 8'h00); p_in[7] = r[7];
               end
               K_DEY, K_INY: begin
                  r = (dec_ff.kind == K_INY) ? y_ff + 8'd1 : y_ff - 8'd1;
                  y_in = r; p_in[1] = (r == 8'h00); p_in[7] = r[7];
               end
               K_JMP: pc_in = (dec_ff.mode == M_IND) ? ea_in : ea_ff;
               K_LDA: begin a_in = m_in; p_in[1] = (m_in == 8'h00); p_in[7] = m_in[7]; end
               K_LDX: begin x_in = m_in; p_in[1] = (m_in == 8'h00); p_in[7] = m_in[7]; end
               K_LDY: begin y_in = m_in; p_in[1] = (m_in == 8'h00); p_in[7] = m_in[7]; end
               default: pc_in = pc_ff + 16'd1;
            endcase
         end
         ST_PUSH: begin
            // Remaining pushes: return low byte, then status for BRK.
            rd_addr = {8'h01, sp_ff};
            ram_we = 1'b1;
            ram_wd = (push_ff == 2'd1 && dec_ff.kind == K_BRK) ? (p_ff | 8'h30) :
                     m_ff;
            if (push_ff == 2'd1 && dec_ff.kind == K_BRK) p_in = p_ff | 8'h14;
            wr_in = 1'b1; wa_in = rd_addr; wd_in = ram_wd;
            sp_in = sp_ff - 8'd1;
            push_in = push_ff - 2'd1;
            if (push_ff == 2'd0) begin
               ram_we = 1'b0; wr_in = wr_ff; wa_in = wa_ff; wd_in = wd_ff;
               sp_in = sp_ff; push_in = push_ff; p_in = p_ff;
            end
         end
         ST_OUT: begin
            rv_in = 1'b1;
            out_in = {6'h0, (dec_ff.kind == K_NONE), wd_ff, wa_ff, wr_ff,
                      p_ff, sp_ff, y_ff, x_ff, a_ff, pc_ff};
         end
         default: ;
      endcase
      ram_addr = rd_addr[AW-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         a_ff <= 8'h00; x_ff <= 8'h00; y_ff <= 8'h00;
         sp_ff <= SP_RESET; p_ff <= 8'h00;
         pc_ff <= VEC_RESET;
         push_ff <= 2'd0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; p_ff <= p_in;
         pc_ff <= pc_in;
         push_ff <= push_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         opc_ff <= req_tdata[7:0];
         lo_ff  <= req_tdata[15:8];
         hi_ff  <= req_tdata[23:16];
         dec_ff <= decode(req_tdata[7:0]);
      end
      ea_ff <= ea_in; m_ff <= m_in;
      wr_ff <= wr_in; wa_ff <= wa_in; wd_ff <= wd_in;
      out_ff <= out_in;
   end

   // Checks.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_tready) else $error("request taken while result pending");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_tvalid) else $error("result during clear");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> (rv_ff && $stable(out_ff)))
      else $error("result changed while stalled");

endmodule

/* test/cpu_6502_instruction_execute_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_6502_instruction_execute_test
// Drives instructions into the 6502 executor and checks each register-file
// result against a local model of the instruction subset, its memory window
// and its stack. A directed opening covers the corner cases, then random
// programs run under four traffic phases, each opened by a vector write.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_execute_test;
   import c6502_pkg::*;

   localparam int RAM_BYTES  = 2048;
   localparam int IDLE_LIMIT = 6000;

   // Result fields from the highest bit down; next_pc sits lowest.
   typedef struct packed {
      logic        unknown;
      logic [7:0]  wdata;
      logic [15:0] waddr;
      logic        wrote;
      logic [7:0]  flags;
      logic [7:0]  sp;
      logic [7:0]  y;
      logic [7:0]  x;
      logic [7:0]  acc;
      logic [15:0] next_pc;
   } cpu_result_type;

   // Local model of the executor with a queue of predicted register files.
   class cpu_scoreboard;
      logic [15:0] brk_vec;
      logic [7:0]  a, x, y, sp, p;
      logic [15:0] pc;
      logic [7:0]  ram [RAM_BYTES];
      cpu_result_type pending_results[$];
      int errors;
      logic        wflag;
      logic [15:0] waddr;
      logic [7:0]  wdata;

      function new();
         brk_vec = VEC_RESET;
         a = 0; x = 0; y = 0; sp = SP_RESET; p = 0; pc = VEC_RESET;
         foreach (ram[i]) ram[i] = 0;
         errors = 0;
      endfunction

      function logic [7:0] rd(logic [15:0] addr);
         return (addr < WINDOW) ? ram[addr[10:0]] : 8'h00;
      endfunction

      function void wr(logic [15:0] addr, logic [7:0] v);
         if (addr < WINDOW) begin
            ram[addr[10:0]] = v;
            wflag = 1; waddr = addr; wdata = v;
         end
      endfunction

      function void push(logic [7:0] v);
         wr({8'h01, sp}, v);
         sp = sp - 8'd1;
      endfunction

      function void set_nz(logic [7:0] v);
         p[1] = (v == 0);
         p[7] = v[7];
      endfunction

      function void compare(logic [7:0] r, logic [7:0] m);
         set_nz(r - m);
         p[0] = (r >= m);
      endfunction

      // Opcode table of the supported subset.
      function void op_table(logic [7:0] opc, output kind_type k, output mode_type md);
         k = K_NONE; md = M_IMPL;
         case (opc)
            8'h69: begin k = K_ADC; md = M_IMM; end   8'h65: begin k = K_ADC; md = M_ZP; end
            8'h75: begin k = K_ADC; md = M_ZPX; end   8'h6D: begin k = K_ADC; md = M_ABS; end
            8'h7D: begin k = K_ADC; md = M_ABSX; end  8'h79: begin k = K_ADC; md = M_ABSY; end
            8'h61: begin k = K_ADC; md = M_INDX; end  8'h71: begin k = K_ADC; md = M_INDY; end
            8'h29: begin k = K_AND; md = M_IMM; end   8'h25: begin k = K_AND; md = M_ZP; end
            8'h35: begin k = K_AND; md = M_ZPX; end   8'h2D: begin k = K_AND; md = M_ABS; end
            8'h3D: begin k = K_AND; md = M_ABSX; end  8'h39: begin k = K_AND; md = M_ABSY; end
            8'h21: begin k = K_AND; md = M_INDX; end  8'h31: begin k = K_AND; md = M_INDY; end
            8'h0A: begin k = K_ASL; md = M_ACC; end   8'h06: begin k = K_ASL; md = M_ZP; end
            8'h16: begin k = K_ASL; md = M_ZPX; end   8'h0E: begin k = K_ASL; md = M_ABS; end
            8'h1E: begin k = K_ASL; md = M_ABSX; end
            8'h90, 8'hB0, 8'hF0, 8'h30, 8'hD0, 8'h50, 8'h70: begin k = K_BR; md = M_REL; end
            8'h24: begin k = K_BIT; md = M_ZP; end    8'h2C: begin k = K_BIT; md = M_ABS; end
            8'h00: k = K_BRK;
            8'h18: k = K_CLC; 8'hD8: k = K_CLD; 8'h58: k = K_CLI; 8'hB8: k = K_CLV;
            8'hC9: begin k = K_CMP; md = M_IMM; end   8'hC5: begin k = K_CMP; md = M_ZP; end
            8'hD5: begin k = K_CMP; md = M_ZPX; end   8'hCD: begin k = K_CMP; md = M_ABS; end
            8'hDD: begin k = K_CMP; md = M_ABSX; end  8'hD9: begin k = K_CMP; md = M_ABSY; end
            8'hC1: begin k = K_CMP; md = M_INDX; end  8'hD1: begin k = K_CMP; md = M_INDY; end
            8'hE0: begin k = K_CPX; md = M_IMM; end   8'hE4: begin k = K_CPX; md = M_ZP; end
            8'hEC: begin k = K_CPX; md = M_ABS; end
            8'hC0: begin k = K_CPY; md = M_IMM; end   8'hC4: begin k = K_CPY; md = M_ZP; end
            8'hCC: begin k = K_CPY; md = M_ABS; end
            8'hC6: begin k = K_DEC; md = M_ZP; end    8'hD6: begin k = K_DEC; md = M_ZPX; end
            8'hCE: begin k = K_DEC; md = M_ABS; end   8'hDE: begin k = K_DEC; md = M_ABSX; end
            8'hCA: k = K_DEX; 8'h88: k = K_DEY; 8'hE8: k = K_INX; 8'hC8: k = K_INY;
            8'h49: begin k = K_EOR; md = M_IMM; end   8'h45: begin k = K_EOR; md = M_ZP; end
            8'h55: begin k = K_EOR; md = M_ZPX; end   8'h4D: begin k = K_EOR; md = M_ABS; end
            8'h5D: begin k = K_EOR; md = M_ABSX; end  8'h59: begin k = K_EOR; md = M_ABSY; end
            8'h41: begin k = K_EOR; md = M_INDX; end  8'h51: begin k = K_EOR; md = M_INDY; end
            8'hE6: begin k = K_INC; md = M_ZP; end    8'hF6: begin k = K_INC; md = M_ZPX; end
            8'hEE: begin k = K_INC; md = M_ABS; end   8'hFE: begin k = K_INC; md = M_ABSX; end
            8'h4C: begin k = K_JMP; md = M_ABS; end   8'h6C: begin k = K_JMP; md = M_IND; end
            8'h20: begin k = K_JSR; md = M_ABS; end
            8'hA9: begin k = K_LDA; md = M_IMM; end   8'hA5: begin k = K_LDA; md = M_ZP; end
            8'hB5: begin k = K_LDA; md = M_ZPX; end   8'hAD: begin k = K_LDA; md = M_ABS; end
            8'hBD: begin k = K_LDA; md = M_ABSX; end  8'hB9: begin k = K_LDA; md = M_ABSY; end
            8'hA1: begin k = K_LDA; md = M_INDX; end  8'hB1: begin k = K_LDA; md = M_INDY; end
            8'hA2: begin k = K_LDX; md = M_IMM; end   8'hA6: begin k = K_LDX; md = M_ZP; end
            8'hB6: begin k = K_LDX; md = M_ZPY; end   8'hAE: begin k = K_LDX; md = M_ABS; end
            8'hBE: begin k = K_LDX; md = M_ABSY; end
            8'hA0: begin k = K_LDY; md = M_IMM; end   8'hA4: begin k = K_LDY; md = M_ZP; end
            8'hB4: begin k = K_LDY; md = M_ZPX; end   8'hAC: begin k = K_LDY; md = M_ABS; end
            8'hBC: begin k = K_LDY; md = M_ABSX; end
            8'h4A: begin k = K_LSR; md = M_ACC; end   8'h46: begin k = K_LSR; md = M_ZP; end
            8'h56: begin k = K_LSR; md = M_ZPX; end   8'h4E: begin k = K_LSR; md = M_ABS; end
            8'h5E: begin k = K_LSR; md = M_ABSX; end
            8'h86: begin k = K_STX; md = M_ZP; end    8'h96: begin k = K_STX; md = M_ZPY; end
            8'h8E: begin k = K_STX; md = M_ABS; end
            default: begin k = K_NONE; md = M_IMPL; end
         endcase
      endfunction

      // Runs one accepted instruction and queues the register file it leaves.
      function void note_instruction(logic [23:0] item);
         logic [7:0]  opc, lo, hi, m, r, ptr;
         logic [15:0] npc, ea, base;
         logic [8:0]  sum;
         kind_type    k;
         mode_type    md;
         cpu_result_type res;
         opc = item[7:0]; lo = item[15:8]; hi = item[23:16];
         wflag = 0; waddr = 0; wdata = 0; m = 0; ea = 0;
         op_table(opc, k, md);
         base = {hi, lo};
         if (md == M_IMPL || md == M_ACC) npc = pc + 16'd1;
         else if (md == M_ABS || md == M_ABSX || md == M_ABSY || md == M_IND) npc = pc + 16'd3;
         else npc = pc + 16'd2;
         // Effective address, with zero-page wrap and the indirect page bug.
         case (md)
            M_ZP:   ea = {8'h00, lo};
            M_ZPX:  ea = {8'h00, lo + x};
            M_ZPY:  ea = {8'h00, lo + y};
            M_ABS:  ea = base;
            M_ABSX: ea = base + x;
            M_ABSY: ea = base + y;
            M_INDX: begin
               ptr = lo + x;
               ea = {rd({8'h00, ptr + 8'd1}), rd({8'h00, ptr})};
            end
            M_INDY: ea = {rd({8'h00, lo + 8'd1}), rd({8'h00, lo})} + y;
            M_IND:  ea = {rd({hi, lo + 8'd1}), rd(base)};
            default: ea = 0;
         endcase
         if (md == M_IMM) m = lo;
         else if (md == M_ACC) m = a;
         else if (md != M_IMPL && md != M_REL && k != K_STX && k != K_JMP && k != K_JSR)
            m = rd(ea);
         case (k)
            K_ADC: begin
               sum = {1'b0, a} + {1'b0, m} + {8'h00, p[0]};
               r = sum[7:0];
               p[0] = sum[8];
               p[6] = ~(a[7] ^ m[7]) & (a[7] ^ r[7]);
               a = r; set_nz(r);
            end
            K_AND: begin a = a & m; set_nz(a); end
            K_EOR: begin a = a ^ m; set_nz(a); end
            K_ASL, K_LSR: begin
               p[0] = (k == K_ASL) ? m[7] : m[0];
               r = (k == K_ASL) ? {m[6:0], 1'b0} : {1'b0, m[7:1]};
               set_nz(r);
               if (md == M_ACC) a = r; else wr(ea, r);
            end
            K_INC, K_DEC: begin
               r = (k == K_INC) ? m + 8'd1 : m - 8'd1;
               set_nz(r); wr(ea, r);
            end
            K_BIT: begin
               p[7] = m[7]; p[6] = m[6]; p[1] = ((m & a) == 0);
            end
            K_BR: begin
               case (opc[7:6])
                  2'd0: r[0] = p[7];
                  2'd1: r[0] = p[6];
                  2'd2: r[0] = p[0];
                  default: r[0] = p[1];
               endcase
               if (r[0] == opc[5]) npc = npc + {{8{lo[7]}}, lo};
            end
            K_BRK: begin
               base = pc + 16'd2;
               push(base[15:8]); push(base[7:0]);
               push(p | 8'h30);
               p = p | 8'h14;
               npc = brk_vec;
            end
            K_CLC: p[0] = 0;
            K_CLD: p[3] = 0;
            K_CLI: p[2] = 0;
            K_CLV: p[6] = 0;
            K_CMP: compare(a, m);
            K_CPX: compare(x, m);
            K_CPY: compare(y, m);
            K_DEX: begin x = x - 8'd1; set_nz(x); end
            K_DEY: begin y = y - 8'd1; set_nz(y); end
            K_INX: begin x = x + 8'd1; set_nz(x); end
            K_INY: begin y = y + 8'd1; set_nz(y); end
            K_JMP: npc = ea;
            K_JSR: begin
               base = pc + 16'd2;
               push(base[15:8]); push(base[7:0]);
               npc = ea;
            end
            K_LDA: begin a = m; set_nz(m); end
            K_LDX: begin x = m; set_nz(m); end
            K_LDY: begin y = m; set_nz(m); end
            K_STX: wr(ea, x);
            default: ;
         endcase
         pc = npc;
         res = '{next_pc: pc, acc: a, x: x, y: y, sp: sp, flags: p, wrote: wflag,
                 waddr: waddr, wdata: wdata, unknown: (k == K_NONE)};
         pending_results.push_back(res);
      endfunction

      task report(string field, logic [15:0] got, logic [15:0] want);
         $display("%0t: %s got %h, want %h", $realtime, field, got, want);
         errors++;
      endtask

      task check_result(logic [87:0] data);
         cpu_result_type got, want;
         got = data[81:0];
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending", $realtime);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
            if (got.acc !== want.acc)         report("acc_out", got.acc, want.acc);
            if (got.x !== want.x)             report("x_out", got.x, want.x);
            if (got.y !== want.y)             report("y_out", got.y, want.y);
            if (got.sp !== want.sp)           report("sp_out", got.sp, want.sp);
            if (got.flags !== want.flags)     report("flags_out", got.flags, want.flags);
            if (got.wrote !== want.wrote)     report("wrote_memory", got.wrote, want.wrote);
            if (got.waddr !== want.waddr)     report("last_write_address", got.waddr, want.waddr);
            if (got.wdata !== want.wdata)     report("last_write_data", got.wdata, want.wdata);
            if (got.unknown !== want.unknown) report("unknown_opcode", got.unknown, want.unknown);
         end
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_RESET_VECTOR;
   logic [15:0] csr_data = 0;

   cpu_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   // Opcodes of the supported subset, used to weight random programs.
   logic [7:0] known_ops[$] = '{
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71, 8'h29, 8'h25, 8'h35, 8'h2D,
      8'h3D, 8'h39, 8'h21, 8'h31, 8'h0A, 8'h06, 8'h16, 8'h0E, 8'h1E, 8'h90, 8'hB0, 8'hF0,
      8'h30, 8'hD0, 8'h50, 8'h70, 8'h24, 8'h2C, 8'h00, 8'h18, 8'hD8, 8'h58, 8'hB8, 8'hC9,
      8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1, 8'hE0, 8'hE4, 8'hEC, 8'hC0, 8'hC4,
      8'hCC, 8'hC6, 8'hD6, 8'hCE, 8'hDE, 8'hCA, 8'h88, 8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D,
      8'h59, 8'h41, 8'h51, 8'hE6, 8'hF6, 8'hEE, 8'hFE, 8'hE8, 8'hC8, 8'h4C, 8'h6C, 8'h20,
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1, 8'hA2, 8'hA6, 8'hB6, 8'hAE,
      8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'h4A, 8'h46, 8'h56, 8'h4E, 8'h5E, 8'h86,
      8'h96, 8'h8E};

   cpu_6502_instruction_execute uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Receiver readiness, stalling at random in the busy phases.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Note accepted instructions and check returned results.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_instruction(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("cpu_6502_instruction_execute: mismatch");
         $finish;
      end
   end

   // One instruction transfer, preceded by random idle cycles.
   task send_instruction(logic [7:0] opc, logic [7:0] lo, logic [7:0] hi);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {hi, lo, opc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task write_register(logic [0:0] idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_BREAK_VECTOR) board.brk_vec = value;
   endtask

   // Hold the sender until every result is back, then let the block settle.
   task drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Operand high byte: mostly inside the RAM window, sometimes anywhere.
   function logic [7:0] pick_high();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 8'($urandom_range(8'h07));
      if (roll < 75) return 8'($urandom_range(8'h1F));
      return 8'($urandom_range(8'hFF));
   endfunction

   task random_item;
      int roll;
      logic [7:0] v;
      roll = $urandom_range(99);
      if (roll < 20) begin
         // Seed memory: load X, then store it to zero page.
         v = 8'($urandom_range(255));
         send_instruction(8'hA2, v, 8'($urandom_range(255)));
         send_instruction(8'h86, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (roll < 32) begin
         // Pointer for the indirect modes: two stores, then a random known opcode on it.
         v = 8'($urandom_range(254));
         send_instruction(8'hA2, 8'($urandom_range(255)), 8'h00);
         send_instruction(8'h86, v, 8'h00);
         send_instruction(8'hA2, 8'($urandom_range(7)), 8'h00);
         send_instruction(8'h86, v + 8'd1, 8'h00);
         send_instruction(known_ops[$urandom_range(known_ops.size() - 1)], v,
                          8'($urandom_range(255)));
      end else if (roll < 90) begin
         send_instruction(known_ops[$urandom_range(known_ops.size() - 1)],
                          8'($urandom_range(255)), pick_high());
      end else begin
         send_instruction(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
      end
   endtask

   initial begin
      int phase;
      int count;
      repeat (6) @(posedge clock);
      reset <= 0;
      write_register(CSR_RESET_VECTOR, 16'hFFFF);
      write_register(CSR_BREAK_VECTOR, 16'h0000);

      // Directed opening: corner cases of each instruction group.
      send_instruction(8'hA9, 8'h00, 8'h00);   // load zero
      send_instruction(8'hA9, 8'hFF, 8'hFF);   // load negative
      send_instruction(8'h69, 8'h01, 8'h00);   // carry out, zero result
      send_instruction(8'hA9, 8'h7F, 8'h00);
      send_instruction(8'h69, 8'h01, 8'h00);   // signed overflow
      send_instruction(8'hC9, 8'h80, 8'h00);   // compare greater
      send_instruction(8'h0A, 8'h00, 8'h00);   // shift left accumulator
      send_instruction(8'h4A, 8'h00, 8'h00);   // shift right accumulator
      send_instruction(8'hA2, 8'h34, 8'h00);
      send_instruction(8'h86, 8'hFF, 8'h00);   // pointer low at top of page zero
      send_instruction(8'h8E, 8'hFF, 8'h1F);   // last byte of the window
      send_instruction(8'h8E, 8'h00, 8'h20);   // outside the window: ignored
      send_instruction(8'hA1, 8'hCB, 8'h00);   // (zp,X) wrapping to page zero
      send_instruction(8'h6C, 8'hFF, 8'h00);   // indirect jump without page carry
      send_instruction(8'h20, 8'h00, 8'h80);   // subroutine call pushes return
      send_instruction(8'h00, 8'h00, 8'h00);   // break to vector zero
      send_instruction(8'hD0, 8'h80, 8'h00);   // branch not taken
      send_instruction(8'hF0, 8'h7F, 8'h00);   // branch taken forwards
      send_instruction(8'hCE, 8'hFF, 8'h1F);   // decrement memory
      send_instruction(8'hFE, 8'hFF, 8'hFF);   // increment outside the window
      send_instruction(8'h2C, 8'hFF, 8'h1F);   // bit test
      send_instruction(8'h58, 8'h00, 8'h00);
      send_instruction(8'hB8, 8'h00, 8'h00);
      send_instruction(8'hD8, 8'h00, 8'h00);
      send_instruction(8'h02, 8'hFF, 8'hFF);   // unknown opcode
      drain();

      // Random programs under four traffic phases.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         case (phase)
            0: write_register(CSR_BREAK_VECTOR, 16'hFFFF);
            1: write_register(CSR_BREAK_VECTOR, 16'($urandom_range(16'hFFFF)));
            2: write_register(CSR_RESET_VECTOR, 16'($urandom_range(16'hFFFF)));
            default: write_register(CSR_BREAK_VECTOR, 16'h0100);
         endcase
         count = 0;
         while (count < 138) begin
            random_item();
            count++;
         end
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      if (board.errors == 0) begin
         $display("cpu_6502_instruction_execute: match");
      end else begin
         $display("cpu_6502_instruction_execute: mismatch");
      end
      $finish;
   end

endmodule

/* cpu_6502_instruction_execute.f */
rtl/c6502_pkg.sv
rtl/c6502_ram.sv
rtl/cpu_6502_instruction_execute.sv
test/cpu_6502_instruction_execute_test.sv
